>>> rtl/pixel_hit_histogram_hot_finder_defines.svh
// Assertion macros shared by the hot pixel finder RTL.
// No dependencies; included by the files that carry assertions.
`ifndef PIXEL_HIT_HISTOGRAM_HOT_FINDER_DEFINES_SVH
`define PIXEL_HIT_HISTOGRAM_HOT_FINDER_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define PHHF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PHHF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/phhf_pkg.sv
// Package for the hot pixel finder: geometry, widths, item and result types.
// No dependencies; used by phhf_engine, the top level and the testbench.
package phhf_pkg;

	localparam int unsigned COLUMNS    = 1024;
	localparam int unsigned ROWS       = 512;
	localparam int unsigned COUNT_BITS = 16;

	localparam int unsigned DEPTH  = COLUMNS * ROWS;
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	localparam int unsigned COL_W   = 10;
	localparam int unsigned ROW_W   = 9;
	localparam int unsigned OUT_W   = 16;
	localparam int unsigned THR_W   = 16;
	// Wide enough to hold COLUMNS and ROWS at their largest.
	localparam int unsigned POS_W   = 13;
	localparam int unsigned CMP_W   = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

	typedef enum logic {
		OP_RECORD = 1'b0,
		OP_REPORT = 1'b1
	} op_t;

	typedef logic [COUNT_BITS-1:0] cnt_t;
	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [THR_W-1:0]      thr_t;

	typedef struct packed {
		op_t              op;
		logic [ROW_W-1:0] pixel_row;
		logic [COL_W-1:0] pixel_col;
	} item_t;

	typedef struct packed {
		logic             is_hot;
		logic [OUT_W-1:0] hit_count;
		logic [ROW_W-1:0] report_row;
		logic [COL_W-1:0] report_col;
	} result_t;

	// Clamp a counter to the width of the hit_count field.
	function automatic logic [OUT_W-1:0] clamp_count(input cnt_t c);
		logic [CMP_W-1:0] wide;
		wide = CMP_W'(c);
		if (wide > CMP_W'({OUT_W{1'b1}})) begin
			return {OUT_W{1'b1}};
		end
		return OUT_W'(wide);
	endfunction

endpackage

>>> rtl/phhf_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies; a read at the address being written returns the old data.
module phhf_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

>>> rtl/phhf_engine.sv
// Counter engine: clearing pass, read-modify-write of the count memory,
// forwarding of the last write. Depends on phhf_pkg and phhf_ram.
`include "pixel_hit_histogram_hot_finder_defines.svh"

module phhf_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  phhf_pkg::item_t   in_item,
	input  phhf_pkg::thr_t    threshold,
	input  logic              out_free,
	output logic              res_valid,
	output phhf_pkg::result_t res
);
	import phhf_pkg::*;

	logic             clr_q;
	addr_t            clr_addr_q;

	logic             valid_s1;
	op_t              op_s1;
	logic             inside_s1;
	addr_t            addr_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;

	logic             fwd_valid_q;
	addr_t            fwd_addr_q;
	cnt_t             fwd_data_q;

	logic             accept;
	logic             adv;
	logic             in_inside;
	addr_t            in_addr;
	cnt_t             rd_data;
	cnt_t             old_cnt;
	cnt_t             cur_cnt;
	cnt_t             new_cnt;
	logic             item_we;
	logic             ram_we;
	addr_t            ram_waddr;
	cnt_t             ram_wdata;

	assign in_inside = (POS_W'(in_item.pixel_col) < POS_W'(COLUMNS))
		&& (POS_W'(in_item.pixel_row) < POS_W'(ROWS));
	assign in_addr = ADDR_W'(in_item.pixel_row) * ADDR_W'(COLUMNS)
		+ ADDR_W'(in_item.pixel_col);

	// A report can leave only when the output register has room.
	assign adv      = valid_s1 && ((op_s1 == OP_RECORD) || out_free);
	assign in_ready = !clr_q && (!valid_s1 || adv);
	assign accept   = in_valid && in_ready;

	// The read was issued as the item entered; the write of the item just
	// ahead lands in the same cycle, so it is taken from the forward register.
	assign old_cnt = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rd_data;
	assign cur_cnt = inside_s1 ? old_cnt : '0;
	assign new_cnt = (op_s1 == OP_REPORT) ? '0
		: ((old_cnt == {COUNT_BITS{1'b1}}) ? old_cnt : old_cnt + cnt_t'(1));

	assign item_we   = adv && inside_s1;
	assign ram_we    = clr_q || item_we;
	assign ram_waddr = clr_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_q ? '0 : new_cnt;

	phhf_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(DEPTH)
	) u_count_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(in_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == addr_t'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + addr_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (item_we) begin
				fwd_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= in_item.op;
			inside_s1 <= in_inside;
			addr_s1   <= in_addr;
			col_s1    <= in_item.pixel_col;
			row_s1    <= in_item.pixel_row;
		end
		if (item_we) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= new_cnt;
		end
	end

	assign res_valid      = adv && (op_s1 == OP_REPORT);
	assign res.report_col = col_s1;
	assign res.report_row = row_s1;
	assign res.hit_count  = clamp_count(cur_cnt);
	assign res.is_hot     = CMP_W'(cur_cnt) > CMP_W'(threshold);

	`PHHF_ASSERT_IMP(a_no_accept_in_clear, clk, arst_n, clr_q, !in_ready,
		"word accepted during the clearing pass")
	`PHHF_ASSERT_IMP(a_write_in_range, clk, arst_n, ram_we && !clr_q, inside_s1 && valid_s1,
		"counter write for a pixel outside the sensor")
	`PHHF_ASSERT_NEXT(a_clear_covers_all, clk, arst_n,
		clr_q && (clr_addr_q != addr_t'(DEPTH - 1)), clr_q,
		"clearing pass ended before the last entry")

endmodule

>>> rtl/pixel_hit_histogram_hot_finder.sv
// Top level of the hot pixel finder: stream ports, threshold register and
// output register. Depends on phhf_pkg and phhf_engine.
//
//  Channel   Direction  Signals                                  Word
//  s_axis    in         s_axis_tvalid/tready/tdata/tuser         one record or report
//  m_axis    out        m_axis_tvalid/tready/tdata               one report result
//  cfg       in         cfg_valid/cfg_ready/cfg_data             hit_threshold write
//
// After reset the count memory is cleared, one entry per cycle, 524288 entries
// (COLUMNS * ROWS); s_axis_tready stays low meanwhile, but cfg writes are taken.
// Then one word is accepted per cycle, unless a report waits in the engine's
// stage; the count memory's read-modify-write sets that rate. A report passes
// that stage and the output register to reach m_axis. A stalled m_axis holds a
// waiting report; s_axis takes words until a second report reaches the stage.
`include "pixel_hit_histogram_hot_finder_defines.svh"

module pixel_hit_histogram_hot_finder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // pixel_col [9:0], pixel_row [18:10], zero pad
	input  logic        s_axis_tuser,   // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // report_col, report_row, hit_count, is_hot, pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import phhf_pkg::*;

	thr_t    thr_q;
	logic    out_valid_q;
	result_t out_q;
	item_t   item;
	logic    out_free;
	logic    res_valid;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	assign item.op        = op_t'(s_axis_tuser);
	assign item.pixel_col = s_axis_tdata[COL_W-1:0];
	assign item.pixel_row = s_axis_tdata[COL_W+ROW_W-1:COL_W];

	assign out_free = !out_valid_q || m_axis_tready;

	phhf_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (item),
		.threshold(thr_q),
		.out_free (out_free),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_q};

	`PHHF_ASSERT_IMP(a_result_has_room, clk, arst_n, res_valid,
		!out_valid_q || m_axis_tready, "result overwrites a word still waiting")
	`PHHF_ASSERT_NEXT(a_out_valid_held, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid, "waiting result word dropped")
	`PHHF_ASSERT_NEXT(a_out_data_held, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		$stable(m_axis_tdata), "waiting result word changed")

endmodule

>>> bench/tb_pixel_hit_histogram_hot_finder.sv
// Testbench for the hot pixel finder: streams record and report words, keeps its
// own per-pixel hit tally and checks every report word field by field.
// Depends on phhf_pkg and the pixel_hit_histogram_hot_finder RTL.
module tb_pixel_hit_histogram_hot_finder;
	timeunit 1ns;
	timeprecision 1ps;

	import phhf_pkg::*;

	// The clearing pass after reset is the longest legal stretch without a handshake.
	localparam int unsigned WATCHDOG_LIMIT = 4 * DEPTH;
	localparam longint unsigned COUNT_TOP = (64'd1 << COUNT_BITS) - 1;
	localparam longint unsigned FIELD_TOP = (64'd1 << OUT_W) - 1;
	localparam int unsigned IDLE_PCT = 18;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned POOL_SIZE = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	bit src_gaps = 1'b1;
	bit sink_stalls = 1'b1;
	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;

	// Predictor state: hits per pixel (absent means zero) and the threshold copy.
	longint unsigned hit_tally [int unsigned];
	logic [THR_W-1:0] threshold = '0;
	result_t pending_reports [$];

	pixel_hit_histogram_hot_finder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_axis_tready <= !sink_stalls || ($urandom_range(99) >= IDLE_PCT);
	end

	task automatic report_mismatch(string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		errors++;
	endtask

	function automatic void tally_word(op_t op, logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
		int unsigned key;
		longint unsigned hits;
		logic on_sensor;
		result_t res;
		on_sensor = (col < COLUMNS) && (row < ROWS);
		key = row * COLUMNS + col;
		hits = 0;
		if (on_sensor && hit_tally.exists(key)) begin
			hits = hit_tally[key];
		end
		if (op == OP_RECORD) begin
			if (on_sensor && hits < COUNT_TOP) begin
				hit_tally[key] = hits + 1;
			end
		end else begin
			if (on_sensor) begin
				hit_tally.delete(key);
			end
			res.report_col = col;
			res.report_row = row;
			res.hit_count  = (hits > FIELD_TOP) ? FIELD_TOP[OUT_W-1:0] : hits[OUT_W-1:0];
			res.is_hot     = hits > threshold;
			pending_reports.insert(pending_reports.size(), res);
		end
	endfunction

	// Predict on the input side first, so a report leaving in its own acceptance cycle would still find its entry.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				tally_word(op_t'(s_axis_tuser), s_axis_tdata[COL_W-1:0],
					s_axis_tdata[COL_W+ROW_W-1:COL_W]);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
				if (pending_reports.size() == 0) begin
					report_mismatch($sformatf("unexpected report word for col %0d row %0d",
						got.report_col, got.report_row));
				end else begin
					want = pending_reports.pop_front();
					if (got.report_col !== want.report_col)
						report_mismatch($sformatf("report_col got %0d expected %0d",
							got.report_col, want.report_col));
					if (got.report_row !== want.report_row)
						report_mismatch($sformatf("report_row got %0d expected %0d",
							got.report_row, want.report_row));
					if (got.hit_count !== want.hit_count)
						report_mismatch($sformatf("hit_count at (%0d,%0d) got %0d expected %0d",
							want.report_col, want.report_row, got.hit_count, want.hit_count));
					if (got.is_hot !== want.is_hot)
						report_mismatch($sformatf("is_hot at (%0d,%0d) got %0b expected %0b",
							want.report_col, want.report_row, got.is_hot, want.is_hot));
				end
			end
			if (cfg_valid && cfg_ready) begin
				threshold = cfg_data;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Enters between words; leaves tvalid high after acceptance so back-to-back words
	// keep it high. stream_idle() drops it when a burst ends.
	task automatic send_word(op_t op, logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
		@(negedge clk);
		while (src_gaps && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, row, col};
		s_axis_tuser  <= op;
		@(posedge clk);
		while (s_axis_tready !== 1'b1) @(posedge clk);
	endtask

	task automatic hit_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row, int unsigned n);
		repeat (n) send_word(OP_RECORD, col, row);
	endtask

	task automatic stream_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic settle();
		stream_idle();
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] value);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reset threshold is zero, so a single hit already makes a pixel hot.
	task automatic test_reset_state();
		send_word(OP_REPORT, 0, 0);
		send_word(OP_REPORT, 1023, 511);
		send_word(OP_REPORT, 1023, 0);
		send_word(OP_REPORT, 0, 511);
		hit_pixel(0, 0, 1);
		hit_pixel(1023, 511, 2);
		hit_pixel(682, 341, 1);
		send_word(OP_REPORT, 0, 0);
		send_word(OP_REPORT, 1023, 511);
		send_word(OP_REPORT, 682, 341);
		send_word(OP_REPORT, 0, 0);
		send_word(OP_REPORT, 341, 170);
	endtask

	task automatic test_threshold_boundary();
		write_threshold(3);
		hit_pixel(5, 7, 3);
		send_word(OP_REPORT, 5, 7);
		hit_pixel(6, 7, 4);
		send_word(OP_REPORT, 6, 7);
		write_threshold(16'hFFFF);
		hit_pixel(1000, 500, 2);
		send_word(OP_REPORT, 1000, 500);
		write_threshold(0);
		hit_pixel(1, 1, 1);
		send_word(OP_REPORT, 1, 1);
	endtask

	// Hammers one counter in one long stretch without idling, so every read
	// overlaps the write of the word just ahead; the second report must read zero.
	task automatic test_long_burst();
		write_threshold(39);
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		hit_pixel(777, 258, 40);
		send_word(OP_REPORT, 777, 258);
		send_word(OP_REPORT, 777, 258);
		settle();
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
	endtask

	// Most hits land in a small window, a few noisy pixels taking half of all hits; the window
	// is then read out row by row with columns rising, as the host scan does.
	task automatic test_raster_scans();
		logic [COL_W-1:0] col0;
		logic [ROW_W-1:0] row0;
		logic [COL_W-1:0] noisy_col [3];
		logic [ROW_W-1:0] noisy_row [3];
		int unsigned pick;
		for (int w = 0; w < 3; w++) begin
			write_threshold((w == 2) ? 16'd0 : 16'($urandom_range(w * 4 + 3)));
			col0 = COL_W'($urandom_range(COLUMNS - 8));
			row0 = ROW_W'($urandom_range(ROWS - 4));
			for (int k = 0; k < 3; k++) begin
				noisy_col[k] = COL_W'(col0 + $urandom_range(7));
				noisy_row[k] = ROW_W'(row0 + $urandom_range(3));
			end
			for (int h = 0; h < 60; h++) begin
				pick = $urandom_range(99);
				if (pick < 50)
					send_word(OP_RECORD, noisy_col[pick % 3], noisy_row[pick % 3]);
				else if (pick < 90)
					send_word(OP_RECORD, COL_W'(col0 + $urandom_range(7)),
						ROW_W'(row0 + $urandom_range(3)));
				else
					send_word(OP_RECORD, COL_W'($urandom_range(COLUMNS - 1)),
						ROW_W'($urandom_range(ROWS - 1)));
			end
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 8; c++) begin
					send_word(OP_REPORT, COL_W'(col0 + c), ROW_W'(row0 + r));
				end
			end
		end
	endtask

	task automatic test_random_traffic();
		logic [COL_W-1:0] pool_col [POOL_SIZE];
		logic [ROW_W-1:0] pool_row [POOL_SIZE];
		logic [THR_W-1:0] phase_thr [4];
		int unsigned pick;
		int unsigned slot;
		phase_thr[0] = THR_W'($urandom_range(6));
		phase_thr[1] = '0;
		phase_thr[2] = 16'hFFFF;
		phase_thr[3] = THR_W'($urandom_range(16'hFFFF));
		for (int p = 0; p < 4; p++) begin
			write_threshold(phase_thr[p]);
			// The second phase runs without any idling on either side.
			src_gaps = (p != 1);
			sink_stalls = (p != 1);
			for (int k = 0; k < POOL_SIZE; k++) begin
				pool_col[k] = COL_W'($urandom_range(COLUMNS - 1));
				pool_row[k] = ROW_W'($urandom_range(ROWS - 1));
			end
			for (int i = 0; i < 130; i++) begin
				pick = $urandom_range(99);
				slot = $urandom_range(POOL_SIZE - 1);
				if (pick < 65)
					send_word(OP_RECORD, pool_col[slot], pool_row[slot]);
				else if (pick < 75)
					send_word(OP_RECORD, COL_W'($urandom_range(COLUMNS - 1)),
						ROW_W'($urandom_range(ROWS - 1)));
				else if (pick < 92)
					send_word(OP_REPORT, pool_col[slot], pool_row[slot]);
				else
					send_word(OP_REPORT, COL_W'($urandom_range(COLUMNS - 1)),
						ROW_W'($urandom_range(ROWS - 1)));
			end
		end
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_threshold_boundary();
		test_long_burst();
		test_raster_scans();
		test_random_traffic();
		settle();
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
